FILE: hw/rtl/i2crm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared constants, action codes, bank defaults and the request and result
// flag types of the I2C register map target.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    localparam int REG_COUNT  = 10;
    localparam int PTR_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int ACT_W      = 3;
    localparam int IDX_W      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int INIT_COUNT = 10;

    localparam logic [PTR_W-1:0] NO_POINTER = {PTR_W{1'b1}};
    localparam logic [PTR_W-1:0] REG_LIMIT  = PTR_W'(REG_COUNT);

    localparam logic [ACT_W-1:0] ACT_WR_MATCH = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RX_BYTE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_MATCH = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TX_DONE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STOP     = 3'd4;

    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
    } t_mem_req;

    typedef struct packed {
        logic tx_valid;
        logic stop_request;
    } t_rsp_flags;

    function automatic logic [BYTE_W-1:0] bank_init(input logic [IDX_W-1:0] idx);
        logic [PTR_W-1:0] wide;
        wide = PTR_W'(idx);
        if (idx == '0) begin
            return 8'd5;
        end else if (wide < PTR_W'(INIT_COUNT)) begin
            return BYTE_W'(wide);
        end else begin
            return '0;
        end
    endfunction

endpackage

FILE: hw/rtl/i2c_register_map_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_map_target
// Byte-level I2C target in front of a small register bank.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one bus event per transfer:
// i_action selects write match, byte received, read match, byte sent or
// stop; i_rx_byte is the received byte. Output channel (o_valid / i_ready)
// returns exactly one result per event: o_tx_valid, o_tx_byte and
// o_stop_request.
// The result is offered from the output register once the bank's
// registered read has returned.
// A new event is not taken while a bank read is in flight: o_ready
// drops in the cycle in which the read is in flight.
// Reset: pointers and armed flags return to their idle values and every
// bank entry reads its default byte until first written; there is no
// clearing pass, events are taken straight after reset.
// Stall: a result held by a low i_ready stays in the output register; one
// further event is then taken only in a cycle where the result leaves.
// ----------------------------------------------------------------------------
module i2c_register_map_target (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [i2crm_pkg::ACT_W-1:0]   i_action,
    input  logic [i2crm_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_tx_valid,
    output logic [i2crm_pkg::BYTE_W-1:0]  o_tx_byte,
    output logic                          o_stop_request
);

    i2crm_pkg::t_mem_req          mem_req;
    i2crm_pkg::t_rsp_flags        flags;
    i2crm_pkg::t_rsp_flags        r_pend_flags;
    i2crm_pkg::t_rsp_flags        r_out_flags;
    logic [i2crm_pkg::BYTE_W-1:0] rd_data;
    logic [i2crm_pkg::BYTE_W-1:0] r_out_byte;
    logic                         r_pend;
    logic                         r_out_valid;
    logic                         take;

    assign o_ready = !r_pend && (!r_out_valid || i_ready);
    assign take    = i_valid && o_ready;

    i2crm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_action  (i_action),
        .i_rx_byte (i_rx_byte),
        .o_req     (mem_req),
        .o_flags   (flags)
    );

    i2crm_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= take;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend_flags <= flags;
        end
        if (r_pend) begin
            r_out_flags <= r_pend_flags;
            r_out_byte  <= rd_data;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tx_valid     = r_out_flags.tx_valid;
    assign o_tx_byte      = r_out_byte;
    assign o_stop_request = r_out_flags.stop_request;

endmodule

FILE: hw/rtl/i2crm_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_bank
// Register bank memory: one write and one registered read port, with a
// written flag per entry so unwritten entries read their default byte.
// ----------------------------------------------------------------------------
module i2crm_bank (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  i2crm_pkg::t_mem_req      i_req,
    output logic [i2crm_pkg::BYTE_W-1:0] o_rd_data
);

    logic [i2crm_pkg::BYTE_W-1:0] r_mem [i2crm_pkg::REG_COUNT];
    logic [i2crm_pkg::REG_COUNT-1:0] r_written;
    logic [i2crm_pkg::BYTE_W-1:0] r_q;
    logic [i2crm_pkg::BYTE_W-1:0] r_dflt;
    logic                         r_q_written;
    logic                         r_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q         <= r_mem[i_req.rd_idx];
            r_q_written <= r_written[i_req.rd_idx];
            r_dflt      <= i2crm_pkg::bank_init(i_req.rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_hit <= i_req.rd_en;
            if (i_req.wr_en) begin
                r_written[i_req.wr_idx] <= 1'b1;
            end
        end
    end

    assign o_rd_data = !r_hit      ? '0 :
                       r_q_written ? r_q : r_dflt;

endmodule

FILE: hw/rtl/i2crm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_ctrl
// Session control: decodes bus events, keeps the pointers and armed flags,
// and issues bank reads and writes.
// ----------------------------------------------------------------------------
module i2crm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [i2crm_pkg::ACT_W-1:0]   i_action,
    input  logic [i2crm_pkg::BYTE_W-1:0]  i_rx_byte,
    output i2crm_pkg::t_mem_req           o_req,
    output i2crm_pkg::t_rsp_flags         o_flags
);

    logic                        r_write_armed, n_write_armed;
    logic                        r_read_armed,  n_read_armed;
    logic [i2crm_pkg::PTR_W-1:0] r_write_ptr,   n_write_ptr;
    logic [i2crm_pkg::PTR_W-1:0] r_read_ptr,    n_read_ptr;
    logic [i2crm_pkg::PTR_W-1:0] rd_ptr;
    logic [i2crm_pkg::PTR_W-1:0] rd_next;
    logic                        rd_want;

    assign rd_next = r_read_ptr + 8'd1;

    always_comb begin
        n_write_armed = r_write_armed;
        n_read_armed  = r_read_armed;
        n_write_ptr   = r_write_ptr;
        n_read_ptr    = r_read_ptr;
        rd_ptr        = r_read_ptr;
        rd_want       = 1'b0;
        o_flags       = '0;
        o_req.wr_en   = 1'b0;
        o_req.wr_idx  = r_write_ptr[i2crm_pkg::IDX_W-1:0];
        o_req.wr_data = i_rx_byte;
        if (i_take) begin
            case (i_action)
                i2crm_pkg::ACT_WR_MATCH: begin
                    n_write_armed = 1'b1;
                end
                i2crm_pkg::ACT_RX_BYTE: begin
                    if (r_write_armed) begin
                        if (r_write_ptr == i2crm_pkg::NO_POINTER) begin
                            n_write_ptr = i_rx_byte;
                            n_read_ptr  = i_rx_byte;
                        end else if (r_write_ptr < i2crm_pkg::REG_LIMIT) begin
                            o_req.wr_en = 1'b1;
                            n_write_ptr = r_write_ptr + 8'd1;
                        end
                    end
                end
                i2crm_pkg::ACT_RD_MATCH: begin
                    n_read_armed     = 1'b1;
                    o_flags.tx_valid = 1'b1;
                    rd_want          = 1'b1;
                end
                i2crm_pkg::ACT_TX_DONE: begin
                    if (r_read_armed) begin
                        o_flags.tx_valid = 1'b1;
                        rd_ptr           = rd_next;
                        rd_want          = 1'b1;
                        if (rd_next >= i2crm_pkg::REG_LIMIT) begin
                            n_read_armed         = 1'b0;
                            n_read_ptr           = '0;
                            o_flags.stop_request = 1'b1;
                        end else begin
                            n_read_ptr = rd_next;
                        end
                    end
                end
                i2crm_pkg::ACT_STOP: begin
                    n_write_armed = 1'b0;
                    n_write_ptr   = i2crm_pkg::NO_POINTER;
                end
                default: begin
                end
            endcase
        end
        o_req.rd_en  = rd_want && (rd_ptr < i2crm_pkg::REG_LIMIT);
        o_req.rd_idx = rd_ptr[i2crm_pkg::IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_armed <= 1'b0;
            r_read_armed  <= 1'b0;
            r_write_ptr   <= i2crm_pkg::NO_POINTER;
            r_read_ptr    <= '0;
        end else begin
            r_write_armed <= n_write_armed;
            r_read_armed  <= n_read_armed;
            r_write_ptr   <= n_write_ptr;
            r_read_ptr    <= n_read_ptr;
        end
    end

endmodule

FILE: hw/rtl/i2crm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks on the I2C register map target, bound to the top level.
// ----------------------------------------------------------------------------
module i2crm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_tx_valid,
    input logic [i2crm_pkg::BYTE_W-1:0]  o_tx_byte,
    input logic                          o_stop_request
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("event taken while bank read in flight");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == '0 && !o_stop_request)
        else $error("byte or stop without transmit");

    a_stop_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stop_request |-> o_tx_valid && o_tx_byte == '0)
        else $error("stop request with non-zero byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte)
            && $stable(o_tx_valid) && $stable(o_stop_request))
        else $error("stalled result changed");

endmodule

bind i2c_register_map_target i2crm_checker u_i2crm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_tx_valid     (o_tx_valid),
    .o_tx_byte      (o_tx_byte),
    .o_stop_request (o_stop_request)
);

FILE: sim/i2crm_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_event_checker
// Watches the event and result channels of the I2C register map target. It
// keeps its own bank, pointers and armed flags, works out the result of each
// accepted bus event, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module i2crm_event_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ev_valid,
    input  logic                          i_ev_ready,
    input  logic [i2crm_pkg::ACT_W-1:0]   i_action,
    input  logic [i2crm_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_tx_valid,
    input  logic [i2crm_pkg::BYTE_W-1:0]  i_tx_byte,
    input  logic                          i_stop_request,
    output int                            o_errors,
    output int                            o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                         tx_valid;
        logic [i2crm_pkg::BYTE_W-1:0] tx_byte;
        logic                         stop_request;
    } t_tx_result;

    logic [i2crm_pkg::BYTE_W-1:0] bank [i2crm_pkg::REG_COUNT];
    logic                         wr_armed;
    logic                         rd_armed;
    logic [i2crm_pkg::PTR_W-1:0]  wr_ptr;
    logic [i2crm_pkg::PTR_W-1:0]  rd_ptr;

    t_tx_result tx_results_due [$];
    t_tx_result due;
    t_tx_result got;
    int         n_fail;
    int         k;

    initial begin
        n_fail = 0;
    end

    function automatic logic [i2crm_pkg::BYTE_W-1:0] bank_byte(
        input logic [i2crm_pkg::PTR_W-1:0] ptr);
        return (ptr < i2crm_pkg::REG_LIMIT) ? bank[ptr] : '0;
    endfunction

    function automatic t_tx_result apply_bus_event(
        input logic [i2crm_pkg::ACT_W-1:0]  act,
        input logic [i2crm_pkg::BYTE_W-1:0] rx);
        t_tx_result r;
        r = '0;
        case (act)
            i2crm_pkg::ACT_WR_MATCH: wr_armed = 1'b1;
            i2crm_pkg::ACT_RX_BYTE: begin
                if (wr_armed) begin
                    if (wr_ptr == i2crm_pkg::NO_POINTER) begin
                        wr_ptr = rx;
                        rd_ptr = rx;
                    end else if (wr_ptr < i2crm_pkg::REG_LIMIT) begin
                        bank[wr_ptr] = rx;
                        wr_ptr       = wr_ptr + 1'b1;
                    end
                end
            end
            i2crm_pkg::ACT_RD_MATCH: begin
                rd_armed   = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte  = bank_byte(rd_ptr);
            end
            i2crm_pkg::ACT_TX_DONE: begin
                if (rd_armed) begin
                    rd_ptr     = rd_ptr + 1'b1;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = bank_byte(rd_ptr);
                    if (rd_ptr >= i2crm_pkg::REG_LIMIT) begin
                        rd_armed       = 1'b0;
                        rd_ptr         = '0;
                        r.stop_request = 1'b1;
                    end
                end
            end
            i2crm_pkg::ACT_STOP: begin
                wr_armed = 1'b0;
                wr_ptr   = i2crm_pkg::NO_POINTER;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < i2crm_pkg::REG_COUNT; k++) begin
                bank[k] = (k == 0) ? 8'd5 :
                          ((k < i2crm_pkg::INIT_COUNT) ? i2crm_pkg::BYTE_W'(k) : '0);
            end
            wr_armed = 1'b0;
            rd_armed = 1'b0;
            wr_ptr   = i2crm_pkg::NO_POINTER;
            rd_ptr   = '0;
            tx_results_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_tx_valid, i_tx_byte, i_stop_request};
                if (tx_results_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing outstanding: tx_valid=%0b",
                                 $realtime, got.tx_valid,
                                 " tx_byte=0x%02h stop_request=%0b",
                                 got.tx_byte, got.stop_request);
                    end
                end else begin
                    due = tx_results_due.pop_front();
                    if (got !== due) begin
                        n_fail++;
                        if (n_fail <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch: expected tx_valid=%0b",
                                     $realtime, due.tx_valid,
                                     " tx_byte=0x%02h stop_request=%0b",
                                     due.tx_byte, due.stop_request,
                                     ", got tx_valid=%0b tx_byte=0x%02h stop_request=%0b",
                                     got.tx_valid, got.tx_byte, got.stop_request);
                        end
                    end
                end
            end
            if (i_ev_valid && i_ev_ready) begin
                tx_results_due.push_back(apply_bus_event(i_action, i_rx_byte));
            end
        end
        o_errors  <= n_fail;
        o_pending <= tx_results_due.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bus events into the I2C register map target: a directed opening
// over pointer loading, dropped bytes, reads past the bank and spare codes,
// then random write and read sessions mixed with noise. Both channels idle
// at random; one long result stall and a full drain halfway through are
// included. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS      = 1200;
    localparam int LATENCY    = 2;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_AT    = 400;
    localparam int ACT_LAST   = (1 << i2crm_pkg::ACT_W) - 1;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [i2crm_pkg::ACT_W-1:0]  i_action;
    logic [i2crm_pkg::BYTE_W-1:0] i_rx_byte;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_tx_valid;
    logic [i2crm_pkg::BYTE_W-1:0] o_tx_byte;
    logic                         o_stop_request;

    int n_errors;
    int n_pending;
    int n_sent;
    int n_taken;
    bit eager_tx;
    bit eager_rx;

    i2c_register_map_target dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_stop_request (o_stop_request)
    );

    i2crm_event_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ev_valid     (i_valid),
        .i_ev_ready     (o_ready),
        .i_action       (i_action),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_tx_valid     (o_tx_valid),
        .i_tx_byte      (o_tx_byte),
        .i_stop_request (o_stop_request),
        .o_errors       (n_errors),
        .o_pending      (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_event(input logic [i2crm_pkg::ACT_W-1:0]  act,
                              input logic [i2crm_pkg::BYTE_W-1:0] rx);
        int gap;
        gap = eager_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        n_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [i2crm_pkg::BYTE_W-1:0] pick_pointer();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return i2crm_pkg::BYTE_W'($urandom_range(0, i2crm_pkg::REG_COUNT - 1));
        if (r < 80) return i2crm_pkg::NO_POINTER;
        if (r < 90) return i2crm_pkg::BYTE_W'($urandom_range(i2crm_pkg::REG_COUNT,
                                                             i2crm_pkg::REG_COUNT + 2));
        return i2crm_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [i2crm_pkg::BYTE_W-1:0] any_byte();
        return i2crm_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // receiver: random gaps, bursts with none, one long hold-off
    initial begin
        int gap;
        i_ready  = 1'b0;
        n_taken  = 0;
        eager_rx = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (n_taken % 64 == 0) eager_rx = ($urandom_range(0, 3) == 0);
            if (n_taken == HOLD_AT) gap = LONG_HOLD;
            else gap = eager_rx ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            n_taken++;
        end
    end

    initial begin
        int  kind;
        int  len;
        int  a;
        bit  paused;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_action  = i2crm_pkg::ACT_WR_MATCH;
        i_rx_byte = '0;
        n_sent    = 0;
        eager_tx  = 1'b0;
        paused    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents, pointer loading and dropped bytes
        send_event(i2crm_pkg::ACT_RD_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_TX_DONE, 8'hFF);
        send_event(i2crm_pkg::ACT_WR_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_RX_BYTE, i2crm_pkg::NO_POINTER);
        send_event(i2crm_pkg::ACT_RX_BYTE, i2crm_pkg::BYTE_W'(i2crm_pkg::REG_COUNT - 2));
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'hFF);
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'h00);
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'hA5);
        send_event(i2crm_pkg::ACT_WR_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'h5A);
        send_event(i2crm_pkg::ACT_STOP, 8'h00);
        // read across the end of the bank
        send_event(i2crm_pkg::ACT_RD_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_TX_DONE, 8'h00);
        send_event(i2crm_pkg::ACT_TX_DONE, 8'h00);
        send_event(i2crm_pkg::ACT_TX_DONE, 8'h00);
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'h33);
        for (a = i2crm_pkg::ACT_STOP + 1; a <= ACT_LAST; a++) begin
            send_event(i2crm_pkg::ACT_W'(a), 8'hC3);
        end
        // pointer beyond the bank
        send_event(i2crm_pkg::ACT_WR_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_RX_BYTE, 8'd200);
        send_event(i2crm_pkg::ACT_STOP, 8'h00);
        send_event(i2crm_pkg::ACT_RD_MATCH, 8'h00);
        send_event(i2crm_pkg::ACT_TX_DONE, 8'h00);

        while (n_sent < ITEMS) begin
            if (!paused && n_sent >= ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            eager_tx = ($urandom_range(0, 4) == 0);
            kind     = $urandom_range(0, 99);
            if (kind < 35) begin
                send_event(i2crm_pkg::ACT_WR_MATCH, any_byte());
                send_event(i2crm_pkg::ACT_RX_BYTE, pick_pointer());
                len = $urandom_range(0, 12);
                repeat (len) send_event(i2crm_pkg::ACT_RX_BYTE, any_byte());
                if ($urandom_range(0, 9) != 0) send_event(i2crm_pkg::ACT_STOP, any_byte());
            end else if (kind < 70) begin
                send_event(i2crm_pkg::ACT_WR_MATCH, any_byte());
                send_event(i2crm_pkg::ACT_RX_BYTE, pick_pointer());
                send_event(i2crm_pkg::ACT_STOP, any_byte());
                send_event(i2crm_pkg::ACT_RD_MATCH, any_byte());
                len = $urandom_range(0, 12);
                repeat (len) send_event(i2crm_pkg::ACT_TX_DONE, any_byte());
                if ($urandom_range(0, 3) != 0) send_event(i2crm_pkg::ACT_STOP, any_byte());
            end else if (kind < 85) begin
                send_event(i2crm_pkg::ACT_RD_MATCH, any_byte());
                len = $urandom_range(0, 5);
                repeat (len) send_event(i2crm_pkg::ACT_TX_DONE, any_byte());
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) begin
                    send_event(i2crm_pkg::ACT_W'($urandom_range(0, ACT_LAST)), any_byte());
                end
            end
        end

        wait_drained();
        @(negedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
